// File: sv/hds_pkg.sv
package hds_pkg;

  // Widths fixed by the register map and the word fields.
  localparam int CNT_W      = 7;   // cell counts and step indexes, 0..127
  localparam int IDX_W      = 6;   // emitted cell index
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;
  localparam int EXT_W      = 32;  // external temperature width, Q16.16
  localparam int FOURIER_W  = 16;
  localparam int SWEEP_W    = 20;
  localparam int FRAC_BITS  = 16;

  localparam int MIN_CELLS  = 3;

  // Register reset values.
  localparam logic [FOURIER_W-1:0] FOURIER_RST = 16'd13107;
  localparam logic [EXT_W-1:0]     BOUND_RST   = 32'd0;
  localparam logic [CNT_W-1:0]     CELLS_RST   = 7'd64;
  localparam logic [SWEEP_W-1:0]   SWEEPS_RST  = 20'd100000;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_FOURIER = 3'd0,
    REG_LEFT    = 3'd1,
    REG_RIGHT   = 3'd2,
    REG_CELLS   = 3'd3,
    REG_SWEEPS  = 3'd4
  } cfg_reg_t;

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_SWEEP = 4'b0010,
    ST_DRAIN = 4'b0100,
    ST_EMIT  = 4'b1000
  } ctrl_state_t;

  // Sequencer to stencil datapath: one stencil step per cycle while sweeping.
  typedef struct packed {
    logic             step_vld;
    logic [CNT_W-1:0] step_idx;
    logic [CNT_W-1:0] last_idx;
  } sweep_cmd_t;

  // Sequencer to the bank ports and the emit path.
  typedef struct packed {
    logic             idle;
    logic             load_we;
    logic [CNT_W-1:0] load_idx;
    logic             rd_en;
    logic [CNT_W-1:0] rd_idx;
    logic             emit_vld;
    logic             emit_last;
    logic             active;
  } mem_cmd_t;

endpackage

// File: sv/heat_diffusion_stencil_1d.sv
// One-dimensional heat diffusion by the explicit FTCS finite-volume scheme.
// Initial cell temperatures (signed Q16.16) are loaded one word per start
// pulse, left cell first, whenever start is high and busy is low. When
// cells_in_use words have arrived (the length is clamped to 3..MAX_CELLS at
// that moment), the block raises busy and runs sweep_count time steps with
// the Fourier number r, alternating between two on-chip banks, then emits
// every cell's final temperature from the left end, one word per cycle on
// out_valid with its index and a last flag. The receiver cannot stall: each
// word is on the out_ ports for exactly one cycle. A sweep streams the source
// bank through a five-stage stencil pipeline at one cell per cycle and
// writes the other bank; the next sweep starts only after the last write of
// the current one. After the word that completes a load, busy stays high
// until the last result has left the bank read stage, and no load word is
// taken while busy is high; with sweep_count at zero the loaded values are
// echoed. The configuration port is always ready and is meant to be
// written while busy is low.
module heat_diffusion_stencil_1d
  import hds_pkg::*;
#(
  parameter int MAX_CELLS = 64,
  parameter int TEMP_BITS = 32
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  output logic                         busy,
  input  logic signed [EXT_W-1:0]      in_cell_temp_in,
  output logic                         out_valid,
  output logic signed [EXT_W-1:0]      out_cell_temp_out,
  output logic [IDX_W-1:0]             out_cell_index,
  output logic                         out_last_cell,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [CFG_IDX_W-1:0]         cfg_index,
  input  logic [CFG_DATA_W-1:0]        cfg_data
);

  localparam int AW = $clog2(MAX_CELLS);
  localparam int BW = (TEMP_BITS > EXT_W) ? TEMP_BITS : EXT_W;

  // Load words are clamped to the bank width.
  function automatic logic signed [TEMP_BITS-1:0] sat_load(input logic signed [EXT_W-1:0] x);
    logic signed [BW-1:0] xw;
    logic                 ovf;
    xw  = BW'(x);
    ovf = !((&xw[BW-1:TEMP_BITS-1]) || !(|xw[BW-1:TEMP_BITS-1]));
    if (ovf) begin
      sat_load = xw[BW-1] ? {1'b1, {(TEMP_BITS-1){1'b0}}} : {1'b0, {(TEMP_BITS-1){1'b1}}};
    end else begin
      sat_load = xw[TEMP_BITS-1:0];
    end
  endfunction

  // Emitted words are clamped to 32 bits.
  function automatic logic signed [EXT_W-1:0] sat_out(input logic signed [TEMP_BITS-1:0] x);
    logic signed [BW-1:0] xw;
    logic                 ovf;
    xw  = BW'(x);
    ovf = !((&xw[BW-1:EXT_W-1]) || !(|xw[BW-1:EXT_W-1]));
    if (ovf) begin
      sat_out = xw[BW-1] ? {1'b1, {(EXT_W-1){1'b0}}} : {1'b0, {(EXT_W-1){1'b1}}};
    end else begin
      sat_out = xw[EXT_W-1:0];
    end
  endfunction

  // Configuration registers.
  logic [FOURIER_W-1:0]    fourier_r;
  logic signed [EXT_W-1:0] left_r, right_r;
  logic [CNT_W-1:0]        cells_r;
  logic [SWEEP_W-1:0]      sweeps_r;

  sweep_cmd_t                  sweep_cmd;
  mem_cmd_t                    mem_cmd;
  logic                        accept;
  logic                        dp_busy;
  logic                        dp_we;
  logic [CNT_W-1:0]            dp_idx;
  logic signed [TEMP_BITS-1:0] dp_data;
  logic signed [TEMP_BITS-1:0] load_data;

  logic                        we_a, we_b;
  logic [AW-1:0]               waddr;
  logic signed [TEMP_BITS-1:0] wdata;
  logic [AW-1:0]               raddr;
  logic [TEMP_BITS-1:0]        rd_a, rd_b;
  logic signed [TEMP_BITS-1:0] rd_data;

  // Emit path: bank read latency, then the output register.
  logic                    e1_vld_r;
  logic [IDX_W-1:0]        e1_idx_r;
  logic                    e1_last_r;
  logic                    out_valid_r;
  logic signed [EXT_W-1:0] out_temp_r;
  logic [IDX_W-1:0]        out_idx_r;
  logic                    out_last_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fourier_r <= FOURIER_RST;
      left_r    <= BOUND_RST;
      right_r   <= BOUND_RST;
      cells_r   <= CELLS_RST;
      sweeps_r  <= SWEEPS_RST;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_FOURIER: fourier_r <= cfg_data[FOURIER_W-1:0];
        REG_LEFT:    left_r    <= cfg_data[EXT_W-1:0];
        REG_RIGHT:   right_r   <= cfg_data[EXT_W-1:0];
        REG_CELLS:   cells_r   <= cfg_data[CNT_W-1:0];
        REG_SWEEPS:  sweeps_r  <= cfg_data[SWEEP_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // Busy covers the whole run, including words still in the bank read stage.
  assign busy   = !mem_cmd.idle || e1_vld_r;
  assign accept = start && !busy;

  hds_ctrl #(
    .MAX_CELLS(MAX_CELLS)
  ) u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .accept      (accept),
    .cells_in_use(cells_r),
    .sweep_count (sweeps_r),
    .dp_busy     (dp_busy),
    .sweep_cmd   (sweep_cmd),
    .mem_cmd     (mem_cmd)
  );

  hds_stencil #(
    .TEMP_BITS(TEMP_BITS)
  ) u_stencil (
    .clk                (clk),
    .rst_n              (rst_n),
    .sweep_cmd          (sweep_cmd),
    .rd_data            (rd_data),
    .fourier_number     (fourier_r),
    .left_boundary_temp (left_r),
    .right_boundary_temp(right_r),
    .wr_en              (dp_we),
    .wr_idx             (dp_idx),
    .wr_data            (dp_data),
    .busy               (dp_busy)
  );

  // Loads go to the active bank; a sweep reads the active bank and writes
  // the other one. The two writers never overlap in time.
  assign load_data = sat_load(in_cell_temp_in);
  assign we_a      = (mem_cmd.load_we && !mem_cmd.active) || (dp_we && mem_cmd.active);
  assign we_b      = (mem_cmd.load_we && mem_cmd.active) || (dp_we && !mem_cmd.active);
  assign waddr     = mem_cmd.load_we ? mem_cmd.load_idx[AW-1:0] : dp_idx[AW-1:0];
  assign wdata     = mem_cmd.load_we ? load_data : dp_data;
  assign raddr     = mem_cmd.rd_idx[AW-1:0];

  hds_bank #(
    .WIDTH(TEMP_BITS),
    .DEPTH(MAX_CELLS)
  ) u_bank_a (
    .clk  (clk),
    .we   (we_a),
    .waddr(waddr),
    .wdata(wdata),
    .re   (mem_cmd.rd_en),
    .raddr(raddr),
    .rdata(rd_a)
  );

  hds_bank #(
    .WIDTH(TEMP_BITS),
    .DEPTH(MAX_CELLS)
  ) u_bank_b (
    .clk  (clk),
    .we   (we_b),
    .waddr(waddr),
    .wdata(wdata),
    .re   (mem_cmd.rd_en),
    .raddr(raddr),
    .rdata(rd_b)
  );

  // The active bank only flips between sweeps, with no read in flight.
  assign rd_data = mem_cmd.active ? $signed(rd_b) : $signed(rd_a);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      e1_vld_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      e1_vld_r    <= mem_cmd.emit_vld;
      out_valid_r <= e1_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    e1_idx_r   <= mem_cmd.rd_idx[IDX_W-1:0];
    e1_last_r  <= mem_cmd.emit_last;
    out_temp_r <= sat_out(rd_data);
    out_idx_r  <= e1_idx_r;
    out_last_r <= e1_last_r;
  end

  assign out_valid         = out_valid_r;
  assign out_cell_temp_out = out_temp_r;
  assign out_cell_index    = out_idx_r;
  assign out_last_cell     = out_last_r;

endmodule

// File: sv/hds_bank.sv
module hds_bank #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// File: sv/hds_ctrl.sv
module hds_ctrl
  import hds_pkg::*;
#(
  parameter int MAX_CELLS = 64
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               accept,
  input  logic [CNT_W-1:0]   cells_in_use,
  input  logic [SWEEP_W-1:0] sweep_count,
  input  logic               dp_busy,
  output sweep_cmd_t         sweep_cmd,
  output mem_cmd_t           mem_cmd
);

  localparam logic [CNT_W-1:0] MAX_N = CNT_W'(MAX_CELLS);
  localparam logic [CNT_W-1:0] MIN_N = CNT_W'(MIN_CELLS);

  ctrl_state_t        state_r, state_nxt;
  logic [CNT_W-1:0]   step_r, step_nxt;
  logic [CNT_W-1:0]   loaded_r, loaded_nxt;
  logic [CNT_W-1:0]   last_r, last_nxt;
  logic [SWEEP_W-1:0] sweeps_r, sweeps_nxt;
  logic               active_r, active_nxt;

  logic [CNT_W-1:0]   n_eff;
  logic [CNT_W-1:0]   loaded_inc;
  logic [CNT_W-1:0]   step_end;
  logic [SWEEP_W-1:0] sweeps_inc;

  // Rod length is clamped at the moment a load is checked for completion.
  always_comb begin
    if (cells_in_use < MIN_N) begin
      n_eff = MIN_N;
    end else if (cells_in_use > MAX_N) begin
      n_eff = MAX_N;
    end else begin
      n_eff = cells_in_use;
    end
  end

  assign loaded_inc = loaded_r + CNT_W'(1);
  assign step_end   = last_r + CNT_W'(1);
  assign sweeps_inc = sweeps_r + SWEEP_W'(1);

  always_comb begin
    state_nxt  = state_r;
    step_nxt   = step_r;
    loaded_nxt = loaded_r;
    last_nxt   = last_r;
    sweeps_nxt = sweeps_r;
    active_nxt = active_r;

    sweep_cmd.step_vld = 1'b0;
    sweep_cmd.step_idx = step_r;
    sweep_cmd.last_idx = last_r;

    mem_cmd.idle      = (state_r == ST_IDLE);
    mem_cmd.load_we   = 1'b0;
    mem_cmd.load_idx  = loaded_r;
    mem_cmd.rd_en     = 1'b0;
    mem_cmd.rd_idx    = step_r;
    mem_cmd.emit_vld  = 1'b0;
    mem_cmd.emit_last = 1'b0;
    mem_cmd.active    = active_r;

    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          mem_cmd.load_we = (loaded_r < MAX_N);
          loaded_nxt      = loaded_inc;
          if (loaded_inc >= n_eff) begin
            loaded_nxt = '0;
            last_nxt   = n_eff - CNT_W'(1);
            step_nxt   = '0;
            sweeps_nxt = '0;
            state_nxt  = (sweep_count == '0) ? ST_EMIT : ST_SWEEP;
          end
        end
      end
      ST_SWEEP: begin
        // One extra step past the last cell flushes the right end cell.
        sweep_cmd.step_vld = 1'b1;
        mem_cmd.rd_en      = (step_r <= last_r);
        if (step_r == step_end) begin
          state_nxt = ST_DRAIN;
        end else begin
          step_nxt = step_r + CNT_W'(1);
        end
      end
      ST_DRAIN: begin
        if (!dp_busy) begin
          active_nxt = ~active_r;
          sweeps_nxt = sweeps_inc;
          step_nxt   = '0;
          state_nxt  = (sweeps_inc == sweep_count) ? ST_EMIT : ST_SWEEP;
        end
      end
      ST_EMIT: begin
        mem_cmd.rd_en     = 1'b1;
        mem_cmd.emit_vld  = 1'b1;
        mem_cmd.emit_last = (step_r == last_r);
        if (step_r == last_r) begin
          step_nxt  = '0;
          state_nxt = ST_IDLE;
        end else begin
          step_nxt = step_r + CNT_W'(1);
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      step_r   <= '0;
      loaded_r <= '0;
      last_r   <= '0;
      sweeps_r <= '0;
      active_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      step_r   <= step_nxt;
      loaded_r <= loaded_nxt;
      last_r   <= last_nxt;
      sweeps_r <= sweeps_nxt;
      active_r <= active_nxt;
    end
  end

endmodule

// File: sv/hds_stencil.sv
module hds_stencil
  import hds_pkg::*;
#(
  parameter int TEMP_BITS = 32
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  sweep_cmd_t                  sweep_cmd,
  input  logic signed [TEMP_BITS-1:0] rd_data,
  input  logic [FOURIER_W-1:0]        fourier_number,
  input  logic signed [EXT_W-1:0]     left_boundary_temp,
  input  logic signed [EXT_W-1:0]     right_boundary_temp,
  output logic                        wr_en,
  output logic [CNT_W-1:0]            wr_idx,
  output logic signed [TEMP_BITS-1:0] wr_data,
  output logic                        busy
);

  localparam int LW = TEMP_BITS + 3;           // Laplacian width
  localparam int PW = LW + FOURIER_W + 1;      // product width
  localparam int SW = LW + 2;                  // sum before saturation
  localparam int BW = (TEMP_BITS > EXT_W) ? TEMP_BITS : EXT_W;

  function automatic logic signed [TEMP_BITS-1:0] sat_ext(input logic signed [EXT_W-1:0] x);
    logic signed [BW-1:0] xw;
    logic                 ovf;
    xw  = BW'(x);
    ovf = !((&xw[BW-1:TEMP_BITS-1]) || !(|xw[BW-1:TEMP_BITS-1]));
    if (ovf) begin
      sat_ext = xw[BW-1] ? {1'b1, {(TEMP_BITS-1){1'b0}}} : {1'b0, {(TEMP_BITS-1){1'b1}}};
    end else begin
      sat_ext = xw[TEMP_BITS-1:0];
    end
  endfunction

  function automatic logic signed [TEMP_BITS-1:0] sat_sum(input logic signed [SW-1:0] x);
    logic ovf;
    ovf = !((&x[SW-1:TEMP_BITS-1]) || !(|x[SW-1:TEMP_BITS-1]));
    if (ovf) begin
      sat_sum = x[SW-1] ? {1'b1, {(TEMP_BITS-1){1'b0}}} : {1'b0, {(TEMP_BITS-1){1'b1}}};
    end else begin
      sat_sum = x[TEMP_BITS-1:0];
    end
  endfunction

  logic signed [TEMP_BITS-1:0] tl_s, tr_s;
  logic signed [FOURIER_W:0]   r_s;

  // Read-data stage and the three-cell window.
  logic                        v1_r, v2_r, v3_r, v4_r, v5_r;
  logic [CNT_W-1:0]            idx1_r, c2_r, c3_r, c4_r, c5_r;
  logic signed [TEMP_BITS-1:0] wl_r, wc_r, wr_r;

  logic signed [LW-1:0]        left_nxt, right_nxt;
  logic signed [LW-1:0]        la_r, ra_r, lap_r, lap_nxt;
  logic signed [TEMP_BITS-1:0] ca_r, cb_r, cc_r;
  logic signed [PW-1:0]        prod_r, prod_nxt;
  logic signed [SW-1:0]        sum;

  assign tl_s = sat_ext(left_boundary_temp);
  assign tr_s = sat_ext(right_boundary_temp);
  assign r_s  = $signed({1'b0, fourier_number});

  // End cells take the ghost-cell form: neighbor = 2 * boundary - own value.
  always_comb begin
    if (c2_r == '0) begin
      left_nxt = (LW'(tl_s) <<< 1) - LW'(wc_r);
    end else begin
      left_nxt = LW'(wl_r);
    end
    if (c2_r == sweep_cmd.last_idx) begin
      right_nxt = (LW'(tr_s) <<< 1) - LW'(wc_r);
    end else begin
      right_nxt = LW'(wr_r);
    end
  end

  assign lap_nxt  = la_r + ra_r - (LW'(ca_r) <<< 1);
  assign prod_nxt = PW'(lap_r) * PW'(r_s);
  assign sum      = SW'(cc_r) + SW'(prod_r >>> FRAC_BITS);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
      v5_r <= 1'b0;
    end else begin
      v1_r <= sweep_cmd.step_vld;
      v2_r <= v1_r && (idx1_r != '0);
      v3_r <= v2_r;
      v4_r <= v3_r;
      v5_r <= v4_r;
    end
  end

  always_ff @(posedge clk) begin
    idx1_r <= sweep_cmd.step_idx;
    if (v1_r) begin
      wl_r <= wc_r;
      wc_r <= wr_r;
      wr_r <= rd_data;
      c2_r <= idx1_r - CNT_W'(1);
    end
    la_r   <= left_nxt;
    ra_r   <= right_nxt;
    ca_r   <= wc_r;
    c3_r   <= c2_r;
    lap_r  <= lap_nxt;
    cb_r   <= ca_r;
    c4_r   <= c3_r;
    prod_r <= prod_nxt;
    cc_r   <= cb_r;
    c5_r   <= c4_r;
  end

  assign wr_en   = v5_r;
  assign wr_idx  = c5_r;
  assign wr_data = sat_sum(sum);
  assign busy    = v1_r | v2_r | v3_r | v4_r | v5_r;

endmodule

// File: bench/tb_heat_diffusion_stencil_1d.sv
`timescale 1ns / 100ps

// Self-checking bench for the 1D explicit heat-diffusion block.
//
// The bench keeps its own copy of the rod: two banks of Q16.16 cells, the
// load count, the active bank and a mirror of the five registers. Every
// accepted load word goes into that copy. When a load completes, the copy
// runs the same number of sweeps and queues one expected word per cell.
// A monitor compares each word on the out_ ports with the oldest queued one.
module tb_heat_diffusion_stencil_1d
  import hds_pkg::*;
;

  localparam int ROD_MAX       = 64;
  localparam int RANDOM_WORDS  = 80;
  localparam int REPORT_LIMIT  = 10;
  localparam int DIRECTED_ROWS = 47;

  // Register indexes beyond the map. Writes to them must change nothing.
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_FIRST = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_LAST  = 3'd7;

  localparam logic signed [EXT_W-1:0] TEMP_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [EXT_W-1:0] TEMP_MIN = 32'sh8000_0000;

  typedef enum logic {ROW_CFG, ROW_CELL} row_kind_t;

  // One line of the directed table. A cell row with holds set must come
  // out of the burst with exactly the temperature it was loaded with.
  typedef struct packed {
    row_kind_t              kind;
    logic [CFG_IDX_W-1:0]   sel;
    logic [CFG_DATA_W-1:0]  value;
    logic                   holds;
  } stim_row_t;

  typedef struct packed {
    logic signed [EXT_W-1:0] temp;
    logic [IDX_W-1:0]        idx;
    logic                    last;
  } cell_result_t;

  logic                    clk = 1'b0;
  logic                    rst_n = 1'b0;
  logic                    start = 1'b0;
  logic                    busy;
  logic signed [EXT_W-1:0] in_cell_temp_in = '0;
  logic                    out_valid;
  logic signed [EXT_W-1:0] out_cell_temp_out;
  logic [IDX_W-1:0]        out_cell_index;
  logic                    out_last_cell;
  logic                    cfg_valid = 1'b0;
  logic                    cfg_ready;
  logic [CFG_IDX_W-1:0]    cfg_index = '0;
  logic [CFG_DATA_W-1:0]   cfg_data = '0;

  always #1 clk = ~clk;

  heat_diffusion_stencil_1d dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .start             (start),
    .busy              (busy),
    .in_cell_temp_in   (in_cell_temp_in),
    .out_valid         (out_valid),
    .out_cell_temp_out (out_cell_temp_out),
    .out_cell_index    (out_cell_index),
    .out_last_cell     (out_last_cell),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data)
  );

  // Directed table. The first phases are picked so that the final rod is
  // known by inspection: zero sweeps echo the load, a rod sitting at its
  // boundary temperature is in equilibrium, and r = 0 freezes everything.
  // The later phases (r above one half with opposite extreme boundaries,
  // and a rod length lowered in the middle of a load) go to the predictor.
  stim_row_t directed_rows [DIRECTED_ROWS] = '{
    // Echo of extreme words with the reset r and boundaries.
    '{ROW_CFG,  REG_SWEEPS,      32'h0000_0000, 1'b0},
    '{ROW_CFG,  REG_CELLS,       32'h0000_0003, 1'b0},
    '{ROW_CFG,  REG_SPARE_FIRST, 32'hFFFF_FFFF, 1'b0},
    '{ROW_CELL, '0,              32'h7FFF_FFFF, 1'b1},
    '{ROW_CELL, '0,              32'h8000_0000, 1'b1},
    '{ROW_CELL, '0,              32'h0001_8000, 1'b1},
    // Length zero clamps to three; a cold rod between cold ends stays cold.
    '{ROW_CFG,  REG_CELLS,       32'h0000_0000, 1'b0},
    '{ROW_CFG,  REG_SWEEPS,      32'h0000_0005, 1'b0},
    '{ROW_CELL, '0,              32'h0000_0000, 1'b1},
    '{ROW_CELL, '0,              32'h0000_0000, 1'b1},
    '{ROW_CELL, '0,              32'h0000_0000, 1'b1},
    // Uniform rod at the boundary temperature with r at one half.
    '{ROW_CFG,  REG_LEFT,        32'h0005_0000, 1'b0},
    '{ROW_CFG,  REG_RIGHT,       32'h0005_0000, 1'b0},
    '{ROW_CFG,  REG_FOURIER,     32'h0000_8000, 1'b0},
    '{ROW_CFG,  REG_SWEEPS,      32'h0000_0007, 1'b0},
    '{ROW_CFG,  REG_CELLS,       32'h0000_0004, 1'b0},
    '{ROW_CELL, '0,              32'h0005_0000, 1'b1},
    '{ROW_CELL, '0,              32'h0005_0000, 1'b1},
    '{ROW_CELL, '0,              32'h0005_0000, 1'b1},
    '{ROW_CELL, '0,              32'h0005_0000, 1'b1},
    // No diffusion at all, even between the most extreme boundaries.
    '{ROW_CFG,  REG_FOURIER,     32'h0000_0000, 1'b0},
    '{ROW_CFG,  REG_LEFT,        32'h8000_0000, 1'b0},
    '{ROW_CFG,  REG_RIGHT,       32'h7FFF_FFFF, 1'b0},
    '{ROW_CFG,  REG_SWEEPS,      32'h0000_0003, 1'b0},
    '{ROW_CFG,  REG_CELLS,       32'h0000_0003, 1'b0},
    '{ROW_CELL, '0,              32'h1234_5678, 1'b1},
    '{ROW_CELL, '0,              32'hFFFF_FFFF, 1'b1},
    '{ROW_CELL, '0,              32'h7FFF_FFFF, 1'b1},
    // Unstable r (all data bits set) drives the rod into saturation.
    '{ROW_CFG,  REG_FOURIER,     32'hFFFF_FFFF, 1'b0},
    '{ROW_CFG,  REG_LEFT,        32'h7FFF_FFFF, 1'b0},
    '{ROW_CFG,  REG_RIGHT,       32'h8000_0000, 1'b0},
    '{ROW_CFG,  REG_SWEEPS,      32'h0000_0004, 1'b0},
    '{ROW_CELL, '0,              32'h4000_0000, 1'b0},
    '{ROW_CELL, '0,              32'h0000_0000, 1'b0},
    '{ROW_CELL, '0,              32'hC000_0000, 1'b0},
    // Eight-cell load cut short: the length drops to three after five
    // words, so the sixth word completes the load and the rest is ignored.
    '{ROW_CFG,  REG_FOURIER,     32'h0000_3333, 1'b0},
    '{ROW_CFG,  REG_LEFT,        32'h0001_0000, 1'b0},
    '{ROW_CFG,  REG_RIGHT,       32'hFFFE_0000, 1'b0},
    '{ROW_CFG,  REG_SWEEPS,      32'h0000_0002, 1'b0},
    '{ROW_CFG,  REG_CELLS,       32'h0000_0008, 1'b0},
    '{ROW_CELL, '0,              32'h0002_0000, 1'b0},
    '{ROW_CELL, '0,              32'hFFFF_8000, 1'b0},
    '{ROW_CELL, '0,              32'h0010_4000, 1'b0},
    '{ROW_CELL, '0,              32'h7FFF_0000, 1'b0},
    '{ROW_CELL, '0,              32'h0000_0001, 1'b0},
    '{ROW_CFG,  REG_CELLS,       32'h0000_0003, 1'b0},
    '{ROW_CELL, '0,              32'h0003_0000, 1'b0}
  };

  // Mirror of the register file, updated on each accepted config word.
  logic [FOURIER_W-1:0]    fourier_q  = FOURIER_RST;
  logic signed [EXT_W-1:0] bound_left  = BOUND_RST;
  logic signed [EXT_W-1:0] bound_right = BOUND_RST;
  logic [CNT_W-1:0]        cells_q    = CELLS_RST;
  logic [SWEEP_W-1:0]      sweeps_q   = SWEEPS_RST;

  // The bench's own rod: two banks plus the load position and active bank.
  logic signed [EXT_W-1:0] rod [2][ROD_MAX];
  bit                      side;
  int                      loaded_cnt;
  bit                      pinned [ROD_MAX];
  logic signed [EXT_W-1:0] pin_temp [ROD_MAX];

  cell_result_t cells_due [$];
  cell_result_t head_cell;

  int fault_count;
  int rods_done;
  int words_loaded;
  int results_checked;
  int deepest_sweeps;

  function automatic logic signed [EXT_W-1:0] clip32(input longint v);
    if (v > longint'(TEMP_MAX)) return TEMP_MAX;
    if (v < longint'(TEMP_MIN)) return TEMP_MIN;
    return v[EXT_W-1:0];
  endfunction

  function automatic int rod_length(input logic [CNT_W-1:0] v);
    if (v < MIN_CELLS) return MIN_CELLS;
    if (v > ROD_MAX) return ROD_MAX;
    return int'(v);
  endfunction

  // One explicit time step over n cells, from the active bank into the
  // other one. The ends see the boundary through a ghost cell, which gives
  // the 3x cell plus 2x boundary form. Each product r * laplacian is
  // floored to Q16.16 by an arithmetic shift.
  task automatic relax_once(input int n);
    int     i;
    longint lap;
    bit     s;
    s = side;
    for (i = 0; i < n; i++) begin
      if (i == 0) begin
        lap = longint'(rod[s][1]) - 3 * longint'(rod[s][0]) + 2 * longint'(bound_left);
      end else if (i == n - 1) begin
        lap = 2 * longint'(bound_right) - 3 * longint'(rod[s][i]) + longint'(rod[s][i-1]);
      end else begin
        lap = longint'(rod[s][i+1]) - 2 * longint'(rod[s][i]) + longint'(rod[s][i-1]);
      end
      rod[!s][i] = clip32(longint'(rod[s][i])
                          + ((lap * longint'(fourier_q)) >>> FRAC_BITS));
    end
    side = !s;
  endtask

  // Takes one accepted load word. On the word that completes the load the
  // rod is relaxed and the whole burst is queued, left cell first.
  task automatic absorb_cell(input logic signed [EXT_W-1:0] t, input logic holds);
    int           n;
    int           i;
    cell_result_t due;
    n = rod_length(cells_q);
    if (loaded_cnt < ROD_MAX) begin
      rod[side][loaded_cnt] = t;
      pinned[loaded_cnt]    = holds;
      pin_temp[loaded_cnt]  = t;
    end
    loaded_cnt++;
    if (loaded_cnt >= n) begin
      for (i = 0; i < int'(sweeps_q); i++) relax_once(n);
      for (i = 0; i < n; i++) begin
        due.temp = pinned[i] ? pin_temp[i] : rod[side][i];
        due.idx  = IDX_W'(i);
        due.last = (i == n - 1);
        cells_due.push_back(due);
      end
      for (i = 0; i < ROD_MAX; i++) pinned[i] = 1'b0;
      if (int'(sweeps_q) > deepest_sweeps) deepest_sweeps = int'(sweeps_q);
      loaded_cnt = 0;
      rods_done++;
    end
  endtask

  task automatic flag_fault(input string what);
    fault_count++;
    if (fault_count <= REPORT_LIMIT) $display("mismatch: %s", what);
  endtask

  // Output monitor. Values are read right after the edge, so they are the
  // ones the edge captured.
  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      if (cells_due.size() == 0) begin
        flag_fault($sformatf("unexpected word, cell %0d temp %h", out_cell_index,
                             out_cell_temp_out));
      end else begin
        head_cell = cells_due.pop_front();
        results_checked++;
        if (out_cell_temp_out !== head_cell.temp)
          flag_fault($sformatf("cell %0d temp expected %h got %h", head_cell.idx,
                               head_cell.temp, out_cell_temp_out));
        if (out_cell_index !== head_cell.idx)
          flag_fault($sformatf("index expected %0d got %0d", head_cell.idx,
                               out_cell_index));
        if (out_last_cell !== head_cell.last)
          flag_fault($sformatf("cell %0d last flag expected %b got %b", head_cell.idx,
                               head_cell.last, out_last_cell));
      end
    end
  end

  // Config word: valid stays up after the handshake so that back-to-back
  // writes never lower and raise it in one step; the caller drops it.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] sel,
                           input logic [CFG_DATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= sel;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (sel)
      REG_FOURIER: fourier_q   = data[FOURIER_W-1:0];
      REG_LEFT:    bound_left  = data[EXT_W-1:0];
      REG_RIGHT:   bound_right = data[EXT_W-1:0];
      REG_CELLS:   cells_q     = data[CNT_W-1:0];
      REG_SWEEPS:  sweeps_q    = data[SWEEP_W-1:0];
      default: ;
    endcase
  endtask

  // Hold the load side off until every queued word has come out and the
  // block has dropped busy.
  task automatic settle();
    start <= 1'b0;
    @(posedge clk);
    while (cells_due.size() != 0 || busy) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  // Sends one load word after an optional gap. start is left high after
  // acceptance; the next call or settle decides whether it drops.
  task automatic push_cell(input logic signed [EXT_W-1:0] t, input logic holds,
                           input int gap);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start           <= 1'b1;
    in_cell_temp_in <= t;
    @(posedge clk);
    while (busy) @(posedge clk);
    words_loaded++;
    absorb_cell(t, holds);
  endtask

  // Mostly back to back or short gaps, now and then a long one.
  function automatic int pick_gap();
    int unsigned sel;
    sel = $urandom_range(0, 9);
    if (sel < 6) return 0;
    if (sel < 9) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Temperatures are mostly within a couple of hundred degrees, so that
  // the sweeps do real work; the rest are any word or a rail.
  function automatic logic signed [EXT_W-1:0] pick_temp();
    int unsigned sel;
    sel = $urandom_range(0, 9);
    if (sel < 6) return int'($urandom_range(0, 26214400)) - 13107200;
    if (sel < 8) return $urandom();
    if (sel < 9) return TEMP_MAX;
    return TEMP_MIN;
  endfunction

  initial begin
    int        r;
    bit        writing;
    stim_row_t row;
    int        episode;
    int        random_from;
    int        cells_val;
    int        sweeps_val;
    int        rod_len;
    int        finished;
    int        j;
    int        break_at;
    bit        broken;
    bit        steady;
    int        fval;
    logic [31:0] noise;

    for (r = 0; r < ROD_MAX; r++) pinned[r] = 1'b0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // Directed table. Runs of config rows are written back to back after
    // the block has gone quiet.
    writing = 1'b0;
    for (r = 0; r < DIRECTED_ROWS; r++) begin
      row = directed_rows[r];
      if (row.kind == ROW_CFG) begin
        if (!writing) settle();
        write_reg(row.sel, row.value);
        writing = 1'b1;
      end else begin
        if (writing) cfg_valid <= 1'b0;
        writing = 1'b0;
        push_cell(row.value, row.holds, pick_gap());
      end
    end

    // Random rods. Each one starts from a quiet block with a fresh length
    // and sweep count (with junk in the unused data bits), and now and then
    // new r and boundaries. The first rod asks for 127 cells, which clamps
    // to the full 64; the second is a long run on a short rod. Long rods
    // get few sweeps to keep the run short.
    random_from = words_loaded;
    episode     = 0;
    while (words_loaded - random_from < RANDOM_WORDS) begin
      settle();
      if (episode == 0) begin
        cells_val = 127;
      end else if (episode == 1) begin
        cells_val = MIN_CELLS;
      end else begin
        j = $urandom_range(0, 19);
        if (j < 13) cells_val = $urandom_range(3, 8);
        else if (j < 17) cells_val = $urandom_range(9, 24);
        else if (j < 18) cells_val = ROD_MAX;
        else if (j < 19) cells_val = $urandom_range(0, 2);
        else cells_val = $urandom_range(65, 127);
      end
      rod_len = rod_length(CNT_W'(cells_val));
      if (episode == 1) begin
        sweeps_val = 3000;
      end else if (rod_len > 24) begin
        sweeps_val = $urandom_range(0, 40);
      end else begin
        j = $urandom_range(0, 9);
        if (j == 0) sweeps_val = 0;
        else if (j == 1) sweeps_val = $urandom_range(100, 600);
        else sweeps_val = $urandom_range(1, 30);
      end

      noise = $urandom();
      write_reg(REG_CELLS, {noise[31:CNT_W], CNT_W'(cells_val)});
      noise = $urandom();
      write_reg(REG_SWEEPS, {noise[31:SWEEP_W], SWEEP_W'(sweeps_val)});
      if ($urandom_range(0, 1) == 1) begin
        fval  = ($urandom_range(0, 4) == 0) ? $urandom_range(32769, 65535)
                                            : $urandom_range(0, 32768);
        noise = $urandom();
        write_reg(REG_FOURIER, {noise[31:FOURIER_W], FOURIER_W'(fval)});
      end
      if ($urandom_range(0, 1) == 1) write_reg(REG_LEFT, pick_temp());
      if ($urandom_range(0, 1) == 1) write_reg(REG_RIGHT, pick_temp());
      if ($urandom_range(0, 5) == 0)
        write_reg(CFG_IDX_W'($urandom_range(REG_SPARE_FIRST, REG_SPARE_LAST)), $urandom());
      cfg_valid <= 1'b0;

      // Now and then the length is rewritten in the middle of the load,
      // which may end it early or stretch it.
      broken   = (sweeps_val <= 40) && ($urandom_range(0, 7) == 0);
      break_at = $urandom_range(1, rod_len - 1);
      steady   = ($urandom_range(0, 3) == 0);
      finished = rods_done;
      j        = 0;
      while (rods_done == finished) begin
        if (broken && j == break_at) begin
          settle();
          write_reg(REG_CELLS, $urandom_range(0, 127));
          cfg_valid <= 1'b0;
        end
        push_cell(pick_temp(), 1'b0, steady ? 0 : pick_gap());
        j++;
      end
      episode++;
    end

    start <= 1'b0;
    @(posedge clk);
    while (cells_due.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);

    $display("Relaxed %0d rods from %0d load words; %0d cell words checked.",
             rods_done, words_loaded, results_checked);
    $display("Longest run %0d sweeps; %0d faults seen.", deepest_sweeps, fault_count);
    if (fault_count == 0 && cells_due.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  // Watchdog, several times the slowest run the stimulus above can make.
  initial begin
    #10_000_000;
    $display("TB_ERROR");
    $finish;
  end

endmodule
